>>> rtl/i2cbm_pkg.sv
package i2cbm_pkg;

    localparam int unsigned STEP_TICKS_WIDTH = 16;
    localparam logic [STEP_TICKS_WIDTH-1:0] STEP_TICKS_RESET = 16'd1000;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_SEND_BYTE = 3'd3,
        OP_RECV_BYTE = 3'd4,
        OP_SEND_ACK  = 3'd5,
        OP_RECV_ACK  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_BUSY   = 2'd1,
        ST_DONE   = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_SCL    = 2'd0,
        K_SDA    = 2'd1,
        K_SAMPLE = 2'd2,
        K_END    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [1:0] status;
        logic [7:0] read_byte;
        logic       ack_seen;
    } out_item_t;

    // classified item as it travels from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] shift_init;
        logic       sda_in;
    } q_item_t;

    typedef struct packed {
        kind_t      kind;
        logic       val;
        logic [2:0] pos;
    } step_t;

    // bit number and phase of a three-step-per-bit sequence, idx below 24
    function automatic logic [4:0] bit_phase(logic [4:0] idx);
        logic [2:0] q;
        logic [1:0] r;
        q = 3'd0;
        r = 2'd0;
        for (int b = 0; b < 8; b++) begin
            if (idx >= 5'(3 * b)) begin
                q = 3'(b);
                r = 2'(idx - 5'(3 * b));
            end
        end
        return {q, r};
    endfunction

    function automatic step_t step_of(op_t cmd, logic [4:0] idx, logic [7:0] shift);
        step_t      s;
        logic [4:0] bp;
        logic [4:0] j;
        s.kind = K_END;
        s.val  = 1'b0;
        s.pos  = 3'd0;
        bp     = 5'd0;
        j      = idx - 5'd1;
        case (cmd)
            OP_START: begin
                case (idx)
                    5'd0: begin s.kind = K_SDA; s.val = 1'b1; end
                    5'd1: begin s.kind = K_SCL; s.val = 1'b1; end
                    5'd2: begin s.kind = K_SDA; s.val = 1'b0; end
                    5'd3: begin s.kind = K_SCL; s.val = 1'b0; end
                    default: s.kind = K_END;
                endcase
            end
            OP_STOP: begin
                case (idx)
                    5'd0: begin s.kind = K_SDA; s.val = 1'b0; end
                    5'd1: begin s.kind = K_SCL; s.val = 1'b1; end
                    5'd2: begin s.kind = K_SDA; s.val = 1'b1; end
                    default: s.kind = K_END;
                endcase
            end
            OP_SEND_BYTE: begin
                if (idx < 5'd24) begin
                    bp = bit_phase(idx);
                    if (bp[1:0] == 2'd0) begin
                        s.kind = K_SDA;
                        s.val  = shift[3'd7 - bp[4:2]];
                    end else begin
                        s.kind = K_SCL;
                        s.val  = (bp[1:0] == 2'd1);
                    end
                end
            end
            OP_RECV_BYTE: begin
                if (idx == 5'd0) begin
                    s.kind = K_SDA;
                    s.val  = 1'b1;
                end else if (idx < 5'd25) begin
                    bp = bit_phase(j);
                    if (bp[1:0] == 2'd1) begin
                        s.kind = K_SAMPLE;
                        s.pos  = 3'd7 - bp[4:2];
                    end else begin
                        s.kind = K_SCL;
                        s.val  = (bp[1:0] == 2'd0);
                    end
                end
            end
            OP_SEND_ACK: begin
                case (idx)
                    5'd0: begin s.kind = K_SDA; s.val = shift[0]; end
                    5'd1: begin s.kind = K_SCL; s.val = 1'b1; end
                    5'd2: begin s.kind = K_SCL; s.val = 1'b0; end
                    default: s.kind = K_END;
                endcase
            end
            OP_RECV_ACK: begin
                case (idx)
                    5'd0: begin s.kind = K_SDA; s.val = 1'b1; end
                    5'd1: begin s.kind = K_SCL; s.val = 1'b1; end
                    5'd2: begin s.kind = K_SAMPLE; s.pos = 3'd0; end
                    5'd3: begin s.kind = K_SCL; s.val = 1'b0; end
                    default: s.kind = K_END;
                endcase
            end
            default: s.kind = K_END;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/i2cbm_front.sv
module i2cbm_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  i2cbm_pkg::in_item_t s_item,
    output logic                push,
    input  logic                q_ready,
    output i2cbm_pkg::q_item_t  q_item
);

    assign s_ready = q_ready;
    assign push    = s_valid && q_ready;

    always_comb begin
        q_item.sda_in     = s_item.sda_in;
        q_item.shift_init = 8'd0;
        case (i2cbm_pkg::op_t'(s_item.operation))
            i2cbm_pkg::OP_START,
            i2cbm_pkg::OP_STOP,
            i2cbm_pkg::OP_RECV_BYTE,
            i2cbm_pkg::OP_RECV_ACK: begin
                q_item.op = i2cbm_pkg::op_t'(s_item.operation);
            end
            i2cbm_pkg::OP_SEND_BYTE: begin
                q_item.op         = i2cbm_pkg::OP_SEND_BYTE;
                q_item.shift_init = s_item.data_byte;
            end
            i2cbm_pkg::OP_SEND_ACK: begin
                q_item.op         = i2cbm_pkg::OP_SEND_ACK;
                q_item.shift_init = {7'd0, (s_item.data_byte != 8'd0)};
            end
            // tick, and the unused code that counts as a tick
            default: begin
                q_item.op = i2cbm_pkg::OP_TICK;
            end
        endcase
    end

endmodule

>>> rtl/i2cbm_queue.sv
module i2cbm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  i2cbm_pkg::q_item_t push_item,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output i2cbm_pkg::q_item_t pop_item
);

    i2cbm_pkg::q_item_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> rtl/i2cbm_back.sv
module i2cbm_back #(
    parameter int unsigned HOLD_COUNTER_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic [i2cbm_pkg::STEP_TICKS_WIDTH-1:0]      step_ticks,
    input  logic                                        q_valid,
    input  i2cbm_pkg::q_item_t                          q_item,
    output logic                                        pop,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output i2cbm_pkg::out_item_t                        m_item
);

    i2cbm_pkg::op_t           active_reg, active_next;
    logic [4:0]               idx_reg, idx_next;
    logic [HOLD_COUNTER_WIDTH-1:0] hold_reg, hold_next;
    logic [7:0]               shift_reg, shift_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic [7:0]               rx_byte_reg, rx_byte_next;
    logic                     rx_ack_reg, rx_ack_next;
    i2cbm_pkg::status_t       status;

    logic                     m_valid_reg;
    i2cbm_pkg::out_item_t     m_item_reg;

    logic [HOLD_COUNTER_WIDTH-1:0] hold_load;
    logic [HOLD_COUNTER_WIDTH-1:0] hold_dec;
    logic [4:0]               idx_inc;
    i2cbm_pkg::step_t         first_step;
    i2cbm_pkg::step_t         tick_step;

    // a zero hold counts as one tick
    assign hold_load = (HOLD_COUNTER_WIDTH'(step_ticks) == '0) ?
                       HOLD_COUNTER_WIDTH'(1) : HOLD_COUNTER_WIDTH'(step_ticks);
    assign hold_dec  = hold_reg - HOLD_COUNTER_WIDTH'(1);
    assign idx_inc   = idx_reg + 5'd1;

    assign pop     = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // step lookups: first step of a new command, next step of the running one
    always_comb begin
        first_step = i2cbm_pkg::step_of(q_item.op, 5'd0, q_item.shift_init);
        tick_step  = i2cbm_pkg::step_of(active_reg, idx_inc, shift_reg);
    end

    // next state of the sequencer for the beat being popped
    always_comb begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        hold_next    = hold_reg;
        shift_next   = shift_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_byte_next = rx_byte_reg;
        rx_ack_next  = rx_ack_reg;
        status       = i2cbm_pkg::ST_IDLE;
        if (q_item.op != i2cbm_pkg::OP_TICK) begin
            if (active_reg != i2cbm_pkg::OP_TICK) begin
                status = i2cbm_pkg::ST_REJECT;
            end else begin
                status      = i2cbm_pkg::ST_BUSY;
                active_next = q_item.op;
                idx_next    = 5'd0;
                shift_next  = q_item.shift_init;
                hold_next   = hold_load;
                case (first_step.kind)
                    i2cbm_pkg::K_SCL: scl_next = first_step.val;
                    i2cbm_pkg::K_SDA: sda_next = first_step.val;
                    default: ;
                endcase
            end
        end else if (active_reg != i2cbm_pkg::OP_TICK) begin
            status    = i2cbm_pkg::ST_BUSY;
            hold_next = hold_dec;
            if (hold_dec == '0) begin
                case (tick_step.kind)
                    i2cbm_pkg::K_END: begin
                        if (active_reg == i2cbm_pkg::OP_RECV_BYTE) begin
                            rx_byte_next = shift_reg;
                        end else if (active_reg == i2cbm_pkg::OP_RECV_ACK) begin
                            rx_ack_next = shift_reg[0];
                        end
                        active_next = i2cbm_pkg::OP_TICK;
                        idx_next    = 5'd0;
                        status      = i2cbm_pkg::ST_DONE;
                    end
                    i2cbm_pkg::K_SCL: begin
                        scl_next  = tick_step.val;
                        idx_next  = idx_inc;
                        hold_next = hold_load;
                    end
                    i2cbm_pkg::K_SDA: begin
                        sda_next  = tick_step.val;
                        idx_next  = idx_inc;
                        hold_next = hold_load;
                    end
                    default: begin
                        shift_next[tick_step.pos] = shift_reg[tick_step.pos] | q_item.sda_in;
                        idx_next  = idx_inc;
                        hold_next = hold_load;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= i2cbm_pkg::OP_TICK;
            idx_reg     <= 5'd0;
            hold_reg    <= '0;
            shift_reg   <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            rx_byte_reg <= 8'd0;
            rx_ack_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                active_reg  <= active_next;
                idx_reg     <= idx_next;
                hold_reg    <= hold_next;
                shift_reg   <= shift_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                rx_byte_reg <= rx_byte_next;
                rx_ack_reg  <= rx_ack_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_item_reg.scl_out   <= scl_next;
            m_item_reg.sda_out   <= sda_next;
            m_item_reg.status    <= status;
            m_item_reg.read_byte <= rx_byte_next;
            m_item_reg.ack_seen  <= rx_ack_next;
        end
    end

endmodule

>>> rtl/i2c_bit_level_master.sv
// Bit-level I2C master for open-drain SCL/SDA (1 = released). Every input beat,
// a tick or a command, yields exactly one result beat with the pin drive, a
// status code, and the last received byte and ack. A command plays its pin
// steps, each held for step_ticks tick beats (zero counts as one); a command
// that arrives while another runs is answered with the rejected status and
// changes nothing. One beat is taken per clock at a sustained rate while results
// are taken; a result passes through a two-entry queue and then the output
// register. The rate is set by the step sequencer, which settles one beat per
// cycle when the output does not stall. step_ticks is written through cfg_* and
// should only change while no command is running.
module i2c_bit_level_master #(
    parameter int unsigned HOLD_COUNTER_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [i2cbm_pkg::STEP_TICKS_WIDTH-1:0] cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  i2cbm_pkg::in_item_t                    s_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output i2cbm_pkg::out_item_t                   m_item
);

    logic [i2cbm_pkg::STEP_TICKS_WIDTH-1:0] step_ticks_reg;
    logic               push;
    logic               q_ready;
    logic               q_valid;
    logic               pop;
    i2cbm_pkg::q_item_t front_item;
    i2cbm_pkg::q_item_t back_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ticks_reg <= i2cbm_pkg::STEP_TICKS_RESET;
        end else if (cfg_valid) begin
            step_ticks_reg <= cfg_data;
        end
    end

    i2cbm_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .push    (push),
        .q_ready (q_ready),
        .q_item  (front_item)
    );

    i2cbm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .push_ready (q_ready),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_item   (back_item)
    );

    i2cbm_back #(
        .HOLD_COUNTER_WIDTH (HOLD_COUNTER_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_ticks (step_ticks_reg),
        .q_valid    (q_valid),
        .q_item     (back_item),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

>>> rtl/i2cbm_checker.sv
module i2cbm_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input i2cbm_pkg::out_item_t m_item
);

    logic       m_beat;
    logic [1:0] prev_status_reg;
    logic       prev_scl_reg;
    logic       prev_sda_reg;
    logic [7:0] prev_byte_reg;

    assign m_beat = m_valid && m_ready;

    // last delivered result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_status_reg <= i2cbm_pkg::ST_IDLE;
            prev_scl_reg    <= 1'b1;
            prev_sda_reg    <= 1'b1;
            prev_byte_reg   <= 8'd0;
        end else if (m_beat) begin
            prev_status_reg <= m_item.status;
            prev_scl_reg    <= m_item.scl_out;
            prev_sda_reg    <= m_item.sda_out;
            prev_byte_reg   <= m_item.read_byte;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_idle_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_item.status == i2cbm_pkg::ST_IDLE |->
            prev_status_reg == i2cbm_pkg::ST_IDLE || prev_status_reg == i2cbm_pkg::ST_DONE)
        else $error("idle reported while a command runs");

    a_reject_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_item.status == i2cbm_pkg::ST_REJECT |->
            m_item.scl_out == prev_scl_reg && m_item.sda_out == prev_sda_reg)
        else $error("rejected command moved a pin");

    a_byte_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_item.read_byte != prev_byte_reg |->
            m_item.status == i2cbm_pkg::ST_DONE)
        else $error("read byte changed outside command end");

endmodule

bind i2c_bit_level_master i2cbm_checker u_checker (.*);

>>> sim/i2c_pin_checker.sv
module i2c_pin_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [i2cbm_pkg::STEP_TICKS_WIDTH-1:0] cfg_data,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  i2cbm_pkg::in_item_t                    s_item,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  i2cbm_pkg::out_item_t                   m_item,
    output int                                     fail_count,
    output int                                     pending
);

    i2cbm_pkg::out_item_t expected_pins[$];
    int                   mismatches = 0;

    // predicted block state
    logic [15:0]    hold_ticks;
    i2cbm_pkg::op_t run_cmd;
    logic [4:0]     step_no;
    logic [15:0]    hold_left;
    logic [7:0]     shift_reg;
    logic           scl_drv;
    logic           sda_drv;
    logic [7:0]     rx_byte;
    logic           rx_ack;

    assign fail_count = mismatches;

    // what step idx of a command does: pin drive, sample position or end of list
    function automatic void next_pin_step(input i2cbm_pkg::op_t cmd, input logic [4:0] idx,
                                          input logic [7:0] sh,
                                          output i2cbm_pkg::kind_t k,
                                          output logic [2:0] v);
        int bn;
        int ph;
        k  = i2cbm_pkg::K_END;
        v  = 3'd0;
        bn = int'(idx) / 3;
        ph = int'(idx) % 3;
        case (cmd)
            i2cbm_pkg::OP_START: begin
                if (idx < 5'd4) begin
                    k = idx[0] ? i2cbm_pkg::K_SCL : i2cbm_pkg::K_SDA;
                    v = {2'd0, ~idx[1]};
                end
            end
            i2cbm_pkg::OP_STOP: begin
                if (idx < 5'd3) begin
                    k = (idx == 5'd1) ? i2cbm_pkg::K_SCL : i2cbm_pkg::K_SDA;
                    v = {2'd0, idx != 5'd0};
                end
            end
            i2cbm_pkg::OP_SEND_BYTE: begin
                if (idx < 5'd24) begin
                    if (ph == 0) begin
                        k = i2cbm_pkg::K_SDA;
                        v = {2'd0, sh[7 - bn]};
                    end else begin
                        k = i2cbm_pkg::K_SCL;
                        v = {2'd0, ph == 1};
                    end
                end
            end
            i2cbm_pkg::OP_RECV_BYTE: begin
                if (idx == 5'd0) begin
                    k = i2cbm_pkg::K_SDA;
                    v = 3'd1;
                end else if (idx < 5'd25) begin
                    bn = (int'(idx) - 1) / 3;
                    ph = (int'(idx) - 1) % 3;
                    if (ph == 1) begin
                        k = i2cbm_pkg::K_SAMPLE;
                        v = 3'(7 - bn);
                    end else begin
                        k = i2cbm_pkg::K_SCL;
                        v = {2'd0, ph == 0};
                    end
                end
            end
            i2cbm_pkg::OP_SEND_ACK: begin
                if (idx == 5'd0) begin
                    k = i2cbm_pkg::K_SDA;
                    v = {2'd0, sh[0]};
                end else if (idx < 5'd3) begin
                    k = i2cbm_pkg::K_SCL;
                    v = {2'd0, idx == 5'd1};
                end
            end
            i2cbm_pkg::OP_RECV_ACK: begin
                if (idx < 5'd4) begin
                    k = (idx == 5'd2) ? i2cbm_pkg::K_SAMPLE :
                        (idx[0] ? i2cbm_pkg::K_SCL : i2cbm_pkg::K_SDA);
                    v = (idx == 5'd2) ? 3'd0 : {2'd0, idx < 5'd2};
                end
            end
            default: k = i2cbm_pkg::K_END;
        endcase
    endfunction

    function automatic bit enter_step(input logic sda);
        i2cbm_pkg::kind_t k;
        logic [2:0]       v;
        next_pin_step(run_cmd, step_no, shift_reg, k, v);
        if (k == i2cbm_pkg::K_END) return 1'b0;
        case (k)
            i2cbm_pkg::K_SCL: scl_drv = v[0];
            i2cbm_pkg::K_SDA: sda_drv = v[0];
            default:          shift_reg[v] = shift_reg[v] | sda;
        endcase
        // a zero setting still holds for one tick
        hold_left = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
        return 1'b1;
    endfunction

    function automatic i2cbm_pkg::out_item_t pin_response(input i2cbm_pkg::in_item_t it);
        i2cbm_pkg::op_t       op;
        i2cbm_pkg::status_t   st;
        i2cbm_pkg::out_item_t r;
        op = (it.operation > i2cbm_pkg::OP_RECV_ACK) ? i2cbm_pkg::OP_TICK :
             i2cbm_pkg::op_t'(it.operation);
        if (op != i2cbm_pkg::OP_TICK) begin
            if (run_cmd != i2cbm_pkg::OP_TICK) begin
                st = i2cbm_pkg::ST_REJECT;
            end else begin
                run_cmd = op;
                step_no = 5'd0;
                case (op)
                    i2cbm_pkg::OP_SEND_BYTE: shift_reg = it.data_byte;
                    i2cbm_pkg::OP_SEND_ACK:  shift_reg = {7'd0, |it.data_byte};
                    default:                 shift_reg = 8'd0;
                endcase
                void'(enter_step(it.sda_in));
                st = i2cbm_pkg::ST_BUSY;
            end
        end else if (run_cmd == i2cbm_pkg::OP_TICK) begin
            st = i2cbm_pkg::ST_IDLE;
        end else begin
            st = i2cbm_pkg::ST_BUSY;
            hold_left = hold_left - 16'd1;
            if (hold_left == 16'd0) begin
                step_no = step_no + 5'd1;
                if (!enter_step(it.sda_in)) begin
                    if (run_cmd == i2cbm_pkg::OP_RECV_BYTE) rx_byte = shift_reg;
                    else if (run_cmd == i2cbm_pkg::OP_RECV_ACK) rx_ack = shift_reg[0];
                    run_cmd = i2cbm_pkg::OP_TICK;
                    step_no = 5'd0;
                    st      = i2cbm_pkg::ST_DONE;
                end
            end
        end
        r.scl_out   = scl_drv;
        r.sda_out   = sda_drv;
        r.status    = st;
        r.read_byte = rx_byte;
        r.ack_seen  = rx_ack;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        i2cbm_pkg::out_item_t want;
        if (!aresetn) begin
            expected_pins.delete();
            hold_ticks = i2cbm_pkg::STEP_TICKS_RESET;
            run_cmd    = i2cbm_pkg::OP_TICK;
            step_no    = 5'd0;
            hold_left  = 16'd0;
            shift_reg  = 8'd0;
            scl_drv    = 1'b1;
            sda_drv    = 1'b1;
            rx_byte    = 8'd0;
            rx_ack     = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) hold_ticks = cfg_data;
            if (m_valid && m_ready) begin
                if (expected_pins.size() == 0) begin
                    $error("result beat with no expectation pending");
                    mismatches++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl_out", 8'(want.scl_out), 8'(m_item.scl_out));
                    check_field("sda_out", 8'(want.sda_out), 8'(m_item.sda_out));
                    check_field("status", 8'(want.status), 8'(m_item.status));
                    check_field("read_byte", want.read_byte, m_item.read_byte);
                    check_field("ack_seen", 8'(want.ack_seen), 8'(m_item.ack_seen));
                end
            end
            if (s_valid && s_ready) expected_pins.push_back(pin_response(s_item));
        end
        pending <= expected_pins.size();
    end

endmodule

>>> sim/tb.sv
module tb;

    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         RANDOM_ITEMS = 100;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [15:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    i2cbm_pkg::in_item_t  s_item;
    logic                 m_valid;
    logic                 m_ready;
    i2cbm_pkg::out_item_t m_item;
    int                   fail_count;
    int                   pending;

    int ticks_now  = int'(i2cbm_pkg::STEP_TICKS_RESET);
    int burst_left = 0;
    int items_sent = 0;
    bit steady     = 1'b0;

    i2c_bit_level_master i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    i2c_pin_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one input beat, with a random gap when a burst runs out and the sender is not steady
    task automatic put_item(input logic [2:0] opc, input logic [7:0] d, input logic sda);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_item  <= '{operation: opc, data_byte: d, sda_in: sda};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // command followed by the ticks it needs, or fewer when cut; noisy adds busy commands in between
    task automatic play(input i2cbm_pkg::op_t op, input logic [7:0] d, input bit noisy,
                        input bit cut);
        int hold;
        int ticks;
        hold = (ticks_now == 0) ? 1 : ticks_now;
        case (op)
            i2cbm_pkg::OP_START, i2cbm_pkg::OP_RECV_ACK: ticks = 4 * hold;
            i2cbm_pkg::OP_STOP, i2cbm_pkg::OP_SEND_ACK:  ticks = 3 * hold;
            i2cbm_pkg::OP_SEND_BYTE:                     ticks = 24 * hold;
            default:                                     ticks = 25 * hold;
        endcase
        if (cut) ticks = $urandom_range(0, ticks - 1);
        put_item(op, d, 1'($urandom));
        for (int i = 0; i < ticks; i++) begin
            if (noisy && (i == 0 || $urandom_range(0, 15) == 0))
                put_item(3'($urandom_range(i2cbm_pkg::OP_START, i2cbm_pkg::OP_RECV_ACK)),
                         8'($urandom), 1'($urandom));
            put_item(($urandom_range(0, 7) == 0) ? OP_UNUSED : 3'(i2cbm_pkg::OP_TICK),
                     8'($urandom), 1'($urandom));
        end
        items_sent += ticks + 1;
    endtask

    // enough ticks to finish whatever is still running
    task automatic drain_command();
        int n;
        n = 25 * ((ticks_now == 0) ? 1 : ticks_now) + 1;
        repeat (n) put_item(i2cbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        items_sent += n;
    endtask

    task automatic write_step_ticks(input logic [15:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        ticks_now  = int'(value);
        burst_left = 0;
    endtask

    // receiver: own stall pattern, with long hold-offs to back up the block
    initial begin
        int mode;
        int span;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        m_ready <= 1'b1;
        repeat (200) @(posedge aclk);
        // one long hold-off while the sender keeps offering beats
        m_ready <= 1'b0;
        repeat (150) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 7);
            span = $urandom_range(20, 400);
            if (mode == 0) begin
                m_ready <= 1'b0;
                repeat (150) @(posedge aclk);
            end else begin
                repeat (span) begin
                    case (mode)
                        1, 2:    m_ready <= 1'b1;
                        3:       m_ready <= ($urandom_range(0, 1) == 1);
                        4:       m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ($urandom_range(0, 9) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
            if (mode == 1) begin
                m_ready <= 1'b0;
                repeat (150) @(posedge aclk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("i2c_bit_level_master verification failed");
        $finish;
    end

    initial begin
        int pick;
        int n;
        int next_cfg;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle ticks, then a start on the reset hold with a busy reject,
        // ticked up to one short of the end of its first step
        put_item(i2cbm_pkg::OP_TICK, 8'hFF, 1'b1);
        put_item(OP_UNUSED, 8'h00, 1'b0);
        put_item(i2cbm_pkg::OP_START, 8'h00, 1'($urandom));
        put_item(i2cbm_pkg::OP_STOP, 8'h00, 1'($urandom));
        repeat (int'(i2cbm_pkg::STEP_TICKS_RESET) - 1)
            put_item(i2cbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));

        write_step_ticks(16'd1);
        // next tick ends the reset-length step, the rest take one tick each
        repeat (4) put_item(i2cbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        play(i2cbm_pkg::OP_SEND_BYTE, 8'hFF, 1'b1, 1'b0);
        play(i2cbm_pkg::OP_SEND_BYTE, 8'h00, 1'b0, 1'b0);
        play(i2cbm_pkg::OP_SEND_BYTE, 8'hA5, 1'b0, 1'b0);
        play(i2cbm_pkg::OP_RECV_BYTE, 8'h5A, 1'b1, 1'b0);
        play(i2cbm_pkg::OP_RECV_ACK, 8'h00, 1'b0, 1'b0);
        play(i2cbm_pkg::OP_SEND_ACK, 8'h00, 1'b0, 1'b0);
        play(i2cbm_pkg::OP_SEND_ACK, 8'h80, 1'b0, 1'b0);
        play(i2cbm_pkg::OP_STOP, 8'hFF, 1'b0, 1'b0);

        // zero setting behaves as one tick
        write_step_ticks(16'd0);
        play(i2cbm_pkg::OP_START, 8'h01, 1'b1, 1'b0);
        play(i2cbm_pkg::OP_RECV_ACK, 8'hFE, 1'b0, 1'b0);

        // one short command, no sender gaps
        write_step_ticks(16'd3);
        steady = 1'b1;
        play(i2cbm_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
        steady = 1'b0;

        write_step_ticks(16'd2);
        items_sent = 0;
        next_cfg   = 300;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= next_cfg) begin
                drain_command();
                write_step_ticks(16'($urandom_range(1, 5)));
                next_cfg = items_sent + 300;
            end
            pick = $urandom_range(0, 19);
            if (pick < 17) begin
                play(i2cbm_pkg::op_t'($urandom_range(i2cbm_pkg::OP_START,
                                                     i2cbm_pkg::OP_RECV_ACK)),
                     8'($urandom), pick < 8, 1'b0);
            end else if (pick < 19) begin
                play(i2cbm_pkg::op_t'($urandom_range(i2cbm_pkg::OP_START,
                                                     i2cbm_pkg::OP_RECV_ACK)),
                     8'($urandom), 1'b1, 1'b1);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n)
                    put_item(($urandom_range(0, 1) == 0) ? OP_UNUSED :
                             3'(i2cbm_pkg::OP_TICK), 8'($urandom), 1'($urandom));
                items_sent += n;
            end
        end
        drain_command();

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("i2c_bit_level_master verification clean");
        else
            $display("i2c_bit_level_master verification failed");
        $finish;
    end

endmodule
